[rtl/mpwa_pkg.sv]
// mpwa_pkg: sizes, register indexes, state codes and sample type shared by the
// max pooling block and its stream interfaces. No dependencies.
package mpwa_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int MAX_POOL    = 8;      // power of two: ring slot is the low row bits
    localparam int SAMPLE_BITS = 16;

    localparam int COORD_BITS  = 10;     // row, column and pooled coordinate fields
    localparam int DIM_BITS    = 11;     // image_width / image_height registers
    localparam int POOL_BITS   = 4;      // pool_size / pool_stride registers
    localparam int PLANE_BITS  = 16;
    localparam int SLOT_BITS   = $clog2(MAX_POOL);
    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int ADDR_BITS   = SLOT_BITS + COL_BITS;
    localparam int STORE_DEPTH = MAX_POOL * MAX_WIDTH;

    localparam int APB_ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 32;

    localparam logic [DIM_BITS-1:0]  WIDTH_RST  = DIM_BITS'(32);
    localparam logic [DIM_BITS-1:0]  HEIGHT_RST = DIM_BITS'(32);
    localparam logic [POOL_BITS-1:0] POOL_RST   = POOL_BITS'(2);
    localparam logic [POOL_BITS-1:0] STRIDE_RST = POOL_BITS'(2);

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_POOL   = 2'd2,
        REG_STRIDE = 2'd3
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_WAIT = 4'b0100,
        ST_PUSH = 4'b1000
    } t_state;

endpackage

[rtl/mpwa_ifs.sv]
// mpwa_sample_if / mpwa_result_if: valid-ready stream channels of the max
// pooling block. Depends on mpwa_pkg.
interface mpwa_sample_if;
    logic                valid;
    logic                ready;
    mpwa_pkg::t_sample   sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface mpwa_result_if;
    logic                                 valid;
    logic                                 ready;
    mpwa_pkg::t_sample                    pooled_max;
    logic [mpwa_pkg::COORD_BITS-1:0]      max_row;
    logic [mpwa_pkg::COORD_BITS-1:0]      max_col;
    logic [mpwa_pkg::COORD_BITS-1:0]      out_row;
    logic [mpwa_pkg::COORD_BITS-1:0]      out_col;
    logic [mpwa_pkg::PLANE_BITS-1:0]      plane_index;

    modport source (output valid, output pooled_max, output max_row, output max_col,
                    output out_row, output out_col, output plane_index, input ready);
    modport sink   (input valid, input pooled_max, input max_row, input max_col,
                    input out_row, input out_col, input plane_index, output ready);
endinterface

[rtl/max_pool_with_argmax.sv]
// max_pool_with_argmax: streaming 2-D max pooling with argmax over a ring line store.
// Depends on mpwa_pkg and the stream interfaces in mpwa_ifs.sv.
//
//  channel    dir   handshake          contents
//  i_sample   in    valid/ready        sample (signed Q8.8, raster order)
//  o_result   out   valid/ready        pooled_max, max_row, max_col, out_row, out_col,
//                                      plane_index
//  apb        in    psel/penable/      image_width, image_height, pool_size, pool_stride
//                   pwrite/pready      at byte addresses 0, 4, 8, 12
//
// a sample that completes no window leaves the block ready; one that completes a
// window is scanned, paced by the single read port of the line store (one window
// element per cycle). ready drops while a window is scanned and while its result
// waits for a full output register. reset is synchronous: counters and config
// return to defaults, the line store is not cleared and needs no clearing.
module max_pool_with_argmax (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    mpwa_sample_if.sink                           i_sample,
    mpwa_result_if.source                         o_result,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [mpwa_pkg::APB_ADDR_BITS-1:0]    paddr,
    input  logic [mpwa_pkg::APB_DATA_BITS-1:0]    pwdata,
    output logic [mpwa_pkg::APB_DATA_BITS-1:0]    prdata,
    output logic                                  pready
);

    localparam int CB = mpwa_pkg::COORD_BITS;
    localparam int DB = mpwa_pkg::DIM_BITS;
    localparam int PB = mpwa_pkg::POOL_BITS;
    localparam int SB = mpwa_pkg::SLOT_BITS;

    // config registers
    logic [DB-1:0] r_width, r_height;
    logic [PB-1:0] r_pool, r_stride;

    // position counters with stride phase and pooled index per axis
    logic [CB-1:0]                   r_row, r_col, n_row, n_col;
    logic [PB-1:0]                   r_row_ph, r_col_ph, n_row_ph, n_col_ph;
    logic [CB-1:0]                   r_row_out, r_col_out, n_row_out, n_col_out;
    logic [mpwa_pkg::PLANE_BITS-1:0] r_plane, n_plane;

    mpwa_pkg::t_state r_state, n_state;

    // window scan
    logic [CB-1:0]                   r_r0, r_c0;
    logic [SB-1:0]                   r_i, r_j;
    logic [CB-1:0]                   r_win_row, r_win_col;
    logic [mpwa_pkg::PLANE_BITS-1:0] r_win_plane;

    // read return tracking and running best
    logic                  r_rd_vld, r_rd_first;
    logic [CB-1:0]         r_rd_row, r_rd_col;
    mpwa_pkg::t_sample     r_rd_data;
    mpwa_pkg::t_sample     r_best;
    logic [CB-1:0]         r_best_row, r_best_col;

    // output register
    logic                  r_out_vld;
    mpwa_pkg::t_sample     r_out_max;
    logic [CB-1:0]         r_out_mrow, r_out_mcol, r_out_orow, r_out_ocol;
    logic [mpwa_pkg::PLANE_BITS-1:0] r_out_plane;

    logic [mpwa_pkg::SAMPLE_BITS-1:0] mem [mpwa_pkg::STORE_DEPTH];

    logic [DB-1:0]                 w_eff, h_eff;
    logic [PB-1:0]                 p_eff, s_eff, p_m1;
    logic                          accept, trigger, cfg_wr, out_free, push;
    logic [DB-1:0]                 col_inc, row_inc;
    logic [CB-1:0]                 scan_row, scan_col;
    logic [mpwa_pkg::ADDR_BITS-1:0] wr_addr, rd_addr;
    logic                          rd_en;
    mpwa_pkg::t_reg_idx            reg_idx;

    // effective config, out-of-range values clamped
    always_comb begin
        if (r_width == '0) begin
            w_eff = DB'(1);
        end else if (r_width > DB'(mpwa_pkg::MAX_WIDTH)) begin
            w_eff = DB'(mpwa_pkg::MAX_WIDTH);
        end else begin
            w_eff = r_width;
        end
        if (r_height == '0) begin
            h_eff = DB'(1);
        end else if (r_height > DB'(mpwa_pkg::MAX_HEIGHT)) begin
            h_eff = DB'(mpwa_pkg::MAX_HEIGHT);
        end else begin
            h_eff = r_height;
        end
        if (r_pool == '0) begin
            p_eff = PB'(1);
        end else if (r_pool > PB'(mpwa_pkg::MAX_POOL)) begin
            p_eff = PB'(mpwa_pkg::MAX_POOL);
        end else begin
            p_eff = r_pool;
        end
        s_eff = (r_stride == '0) ? PB'(1) : r_stride;
        p_m1  = p_eff - PB'(1);
    end

    assign pready         = 1'b1;
    assign cfg_wr         = psel & penable & pwrite;
    assign reg_idx        = mpwa_pkg::t_reg_idx'(paddr[3:2]);
    assign i_sample.ready = (r_state == mpwa_pkg::ST_IDLE);
    assign accept         = i_sample.valid & i_sample.ready;
    assign out_free       = ~r_out_vld | o_result.ready;
    assign push           = (r_state == mpwa_pkg::ST_PUSH) & out_free;

    always_comb begin
        unique case (reg_idx)
            mpwa_pkg::REG_WIDTH:  prdata = {{(mpwa_pkg::APB_DATA_BITS-DB){1'b0}}, r_width};
            mpwa_pkg::REG_HEIGHT: prdata = {{(mpwa_pkg::APB_DATA_BITS-DB){1'b0}}, r_height};
            mpwa_pkg::REG_POOL:   prdata = {{(mpwa_pkg::APB_DATA_BITS-PB){1'b0}}, r_pool};
            mpwa_pkg::REG_STRIDE: prdata = {{(mpwa_pkg::APB_DATA_BITS-PB){1'b0}}, r_stride};
            default:              prdata = '0;
        endcase
    end

    // window completes at its bottom-right corner on a stride phase of zero
    assign trigger = (r_row >= CB'(p_m1)) && (r_col >= CB'(p_m1))
                     && (r_row_ph == '0) && (r_col_ph == '0);

    assign col_inc = {1'b0, r_col} + DB'(1);
    assign row_inc = {1'b0, r_row} + DB'(1);

    // position update
    always_comb begin
        n_row     = r_row;
        n_col     = r_col;
        n_row_ph  = r_row_ph;
        n_col_ph  = r_col_ph;
        n_row_out = r_row_out;
        n_col_out = r_col_out;
        n_plane   = r_plane;
        if (cfg_wr) begin
            n_row     = '0;
            n_col     = '0;
            n_row_ph  = '0;
            n_col_ph  = '0;
            n_row_out = '0;
            n_col_out = '0;
        end else if (accept) begin
            if (col_inc >= w_eff) begin
                n_col     = '0;
                n_col_ph  = '0;
                n_col_out = '0;
                if (row_inc >= h_eff) begin
                    n_row     = '0;
                    n_row_ph  = '0;
                    n_row_out = '0;
                    n_plane   = r_plane + 1'b1;
                end else begin
                    n_row = row_inc[CB-1:0];
                    if (row_inc == DB'(p_m1)) begin
                        n_row_ph  = '0;
                        n_row_out = '0;
                    end else if (row_inc > DB'(p_m1)) begin
                        if (r_row_ph + PB'(1) == s_eff) begin
                            n_row_ph  = '0;
                            n_row_out = r_row_out + 1'b1;
                        end else begin
                            n_row_ph = r_row_ph + PB'(1);
                        end
                    end
                end
            end else begin
                n_col = col_inc[CB-1:0];
                if (col_inc == DB'(p_m1)) begin
                    n_col_ph  = '0;
                    n_col_out = '0;
                end else if (col_inc > DB'(p_m1)) begin
                    if (r_col_ph + PB'(1) == s_eff) begin
                        n_col_ph  = '0;
                        n_col_out = r_col_out + 1'b1;
                    end else begin
                        n_col_ph = r_col_ph + PB'(1);
                    end
                end
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mpwa_pkg::ST_IDLE: begin
                if (accept && trigger) begin
                    n_state = mpwa_pkg::ST_SCAN;
                end
            end
            mpwa_pkg::ST_SCAN: begin
                if ((r_i == p_m1[SB-1:0]) && (r_j == p_m1[SB-1:0])) begin
                    n_state = mpwa_pkg::ST_WAIT;
                end
            end
            mpwa_pkg::ST_WAIT: n_state = mpwa_pkg::ST_PUSH;
            mpwa_pkg::ST_PUSH: begin
                if (out_free) begin
                    n_state = mpwa_pkg::ST_IDLE;
                end
            end
            default: n_state = mpwa_pkg::ST_IDLE;
        endcase
    end

    assign scan_row = r_r0 + CB'(r_i);
    assign scan_col = r_c0 + CB'(r_j);
    assign rd_en    = (r_state == mpwa_pkg::ST_SCAN);
    assign rd_addr  = {scan_row[SB-1:0], scan_col[mpwa_pkg::COL_BITS-1:0]};
    assign wr_addr  = {r_row[SB-1:0], r_col[mpwa_pkg::COL_BITS-1:0]};

    // line store: sample written on accept, window read one element per cycle
    always_ff @(posedge i_clk) begin
        if (accept) begin
            mem[wr_addr] <= i_sample.sample;
        end
        if (rd_en) begin
            r_rd_data <= mpwa_pkg::t_sample'(mem[rd_addr]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= mpwa_pkg::WIDTH_RST;
            r_height  <= mpwa_pkg::HEIGHT_RST;
            r_pool    <= mpwa_pkg::POOL_RST;
            r_stride  <= mpwa_pkg::STRIDE_RST;
            r_row     <= '0;
            r_col     <= '0;
            r_row_ph  <= '0;
            r_col_ph  <= '0;
            r_row_out <= '0;
            r_col_out <= '0;
            r_plane   <= '0;
            r_state   <= mpwa_pkg::ST_IDLE;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (cfg_wr) begin
                unique case (reg_idx)
                    mpwa_pkg::REG_WIDTH:  r_width  <= pwdata[DB-1:0];
                    mpwa_pkg::REG_HEIGHT: r_height <= pwdata[DB-1:0];
                    mpwa_pkg::REG_POOL:   r_pool   <= pwdata[PB-1:0];
                    mpwa_pkg::REG_STRIDE: r_stride <= pwdata[PB-1:0];
                    default: ;
                endcase
            end
            r_row     <= n_row;
            r_col     <= n_col;
            r_row_ph  <= n_row_ph;
            r_col_ph  <= n_col_ph;
            r_row_out <= n_row_out;
            r_col_out <= n_col_out;
            r_plane   <= n_plane;
            r_state   <= n_state;
            r_rd_vld  <= rd_en;
            if (push) begin
                r_out_vld <= 1'b1;
            end else if (o_result.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // scan indices and window bookkeeping
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_r0        <= r_row - CB'(p_m1);
            r_c0        <= r_col - CB'(p_m1);
            r_win_row   <= r_row_out;
            r_win_col   <= r_col_out;
            r_win_plane <= r_plane;
            r_i         <= '0;
            r_j         <= '0;
        end else if (rd_en) begin
            if (r_j == p_m1[SB-1:0]) begin
                r_j <= '0;
                r_i <= r_i + 1'b1;
            end else begin
                r_j <= r_j + 1'b1;
            end
        end
        if (rd_en) begin
            r_rd_row   <= scan_row;
            r_rd_col   <= scan_col;
            r_rd_first <= (r_i == '0) && (r_j == '0);
        end
        // first element seeds the maximum, later ones replace it only when larger
        if (r_rd_vld && (r_rd_first || (r_rd_data > r_best))) begin
            r_best     <= r_rd_data;
            r_best_row <= r_rd_row;
            r_best_col <= r_rd_col;
        end
        if (push) begin
            r_out_max   <= r_best;
            r_out_mrow  <= r_best_row;
            r_out_mcol  <= r_best_col;
            r_out_orow  <= r_win_row;
            r_out_ocol  <= r_win_col;
            r_out_plane <= r_win_plane;
        end
    end

    assign o_result.valid       = r_out_vld;
    assign o_result.pooled_max  = r_out_max;
    assign o_result.max_row     = r_out_mrow;
    assign o_result.max_col     = r_out_mcol;
    assign o_result.out_row     = r_out_orow;
    assign o_result.out_col     = r_out_ocol;
    assign o_result.plane_index = r_out_plane;

endmodule
